### src/assert_macros.svh
// Assertion macros included by the converter top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/i2p_pkg.sv
// Constants, types and microcode table of the infix to postfix converter.
package i2p_pkg;

   localparam int STACK_DEPTH = 32;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int CHAR_W      = 8;
   localparam int ERR_W       = 3;
   localparam int CODE_W      = 3;
   localparam int STEP_W      = 5;

   // stacked operator codes
   localparam logic [CODE_W-1:0] OP_PAREN = 3'd0;
   localparam logic [CODE_W-1:0] OP_POW   = 3'd1;
   localparam logic [CODE_W-1:0] OP_MUL   = 3'd2;
   localparam logic [CODE_W-1:0] OP_DIV   = 3'd3;
   localparam logic [CODE_W-1:0] OP_ADD   = 3'd4;
   localparam logic [CODE_W-1:0] OP_SUB   = 3'd5;

   localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
   localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
   localparam logic [CHAR_W-1:0] CH_POW    = 8'h5E;
   localparam logic [CHAR_W-1:0] CH_MUL    = 8'h2A;
   localparam logic [CHAR_W-1:0] CH_DIV    = 8'h2F;
   localparam logic [CHAR_W-1:0] CH_ADD    = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_SUB    = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'd65;
   localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'd90;
   localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'd97;
   localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'd122;

   localparam logic [ERR_W-1:0] ERR_NONE     = 3'd0;
   localparam logic [ERR_W-1:0] ERR_CLOSE    = 3'd1;
   localparam logic [ERR_W-1:0] ERR_OPEN     = 3'd2;
   localparam logic [ERR_W-1:0] ERR_OVERFLOW = 3'd3;
   localparam logic [ERR_W-1:0] ERR_BAD_CHAR = 3'd4;

   // microcode step addresses
   localparam logic [STEP_W-1:0] STEP_IDLE = 5'd0;
   localparam logic [STEP_W-1:0] STEP_DISP = 5'd1;
   localparam logic [STEP_W-1:0] STEP_LET  = 5'd2;
   localparam logic [STEP_W-1:0] STEP_BAD  = 5'd3;
   localparam logic [STEP_W-1:0] STEP_CLS  = 5'd4;
   localparam logic [STEP_W-1:0] STEP_CLS2 = 5'd5;
   localparam logic [STEP_W-1:0] STEP_CLS3 = 5'd6;
   localparam logic [STEP_W-1:0] STEP_CLSP = 5'd7;
   localparam logic [STEP_W-1:0] STEP_CLSE = 5'd8;
   localparam logic [STEP_W-1:0] STEP_OPC  = 5'd9;
   localparam logic [STEP_W-1:0] STEP_OPC2 = 5'd10;
   localparam logic [STEP_W-1:0] STEP_OPC3 = 5'd11;
   localparam logic [STEP_W-1:0] STEP_PUSH = 5'd12;
   localparam logic [STEP_W-1:0] STEP_END  = 5'd13;
   localparam logic [STEP_W-1:0] STEP_FL   = 5'd14;
   localparam logic [STEP_W-1:0] STEP_FL2  = 5'd15;
   localparam logic [STEP_W-1:0] STEP_TAIL = 5'd16;
   localparam logic [STEP_W-1:0] STEP_DONE = 5'd17;

   typedef enum logic [3:0] {
      A_NONE,
      A_LATCH,
      A_LETTER,
      A_BAD,
      A_EMIT_TOP,
      A_POP,
      A_ERR_CLOSE,
      A_PUSH,
      A_POP_FLUSH,
      A_TAIL,
      A_RELEASE
   } act_type;

   typedef enum logic [2:0] {
      J_NEXT,
      J_GOTO,
      J_IF_NOT_FIRE,
      J_DISPATCH,
      J_IF_CNT0,
      J_IF_PAREN,
      J_IF_STOP,
      J_IF_NOT_END
   } jump_type;

   typedef struct packed {
      act_type           act;
      jump_type          jmp;
      logic [STEP_W-1:0] target;
      logic              out_use;
   } cword_type;

   function automatic cword_type cw(input act_type a, input jump_type j,
                                    input logic [STEP_W-1:0] t, input logic o);
      cword_type w;
      w.act     = a;
      w.jmp     = j;
      w.target  = t;
      w.out_use = o;
      return w;
   endfunction

   function automatic cword_type ucode_rom(input logic [STEP_W-1:0] step);
      cword_type w;
      case (step)
         STEP_IDLE: w = cw(A_LATCH,     J_IF_NOT_FIRE, STEP_IDLE, 1'b0);
         STEP_DISP: w = cw(A_NONE,      J_DISPATCH,    STEP_IDLE, 1'b0);
         STEP_LET:  w = cw(A_LETTER,    J_GOTO,        STEP_END,  1'b1);
         STEP_BAD:  w = cw(A_BAD,       J_GOTO,        STEP_END,  1'b1);
         STEP_CLS:  w = cw(A_NONE,      J_IF_CNT0,     STEP_CLSE, 1'b0);
         STEP_CLS2: w = cw(A_NONE,      J_IF_PAREN,    STEP_CLSP, 1'b0);
         STEP_CLS3: w = cw(A_EMIT_TOP,  J_GOTO,        STEP_CLS,  1'b1);
         STEP_CLSP: w = cw(A_POP,       J_GOTO,        STEP_END,  1'b0);
         STEP_CLSE: w = cw(A_ERR_CLOSE, J_GOTO,        STEP_END,  1'b1);
         STEP_OPC:  w = cw(A_NONE,      J_IF_CNT0,     STEP_PUSH, 1'b0);
         STEP_OPC2: w = cw(A_NONE,      J_IF_STOP,     STEP_PUSH, 1'b0);
         STEP_OPC3: w = cw(A_EMIT_TOP,  J_GOTO,        STEP_OPC,  1'b1);
         STEP_PUSH: w = cw(A_PUSH,      J_NEXT,        STEP_IDLE, 1'b1);
         STEP_END:  w = cw(A_NONE,      J_IF_NOT_END,  STEP_DONE, 1'b0);
         STEP_FL:   w = cw(A_NONE,      J_IF_CNT0,     STEP_TAIL, 1'b0);
         STEP_FL2:  w = cw(A_POP_FLUSH, J_GOTO,        STEP_FL,   1'b1);
         STEP_TAIL: w = cw(A_TAIL,      J_NEXT,        STEP_IDLE, 1'b1);
         STEP_DONE: w = cw(A_RELEASE,   J_GOTO,        STEP_IDLE, 1'b1);
         default:   w = cw(A_NONE,      J_GOTO,        STEP_IDLE, 1'b0);
      endcase
      return w;
   endfunction

   // {is_operator_or_open, code}
   function automatic logic [CODE_W:0] op_lookup(input logic [CHAR_W-1:0] c);
      logic [CODE_W:0] r;
      case (c)
         CH_LPAREN: r = {1'b1, OP_PAREN};
         CH_POW:    r = {1'b1, OP_POW};
         CH_MUL:    r = {1'b1, OP_MUL};
         CH_DIV:    r = {1'b1, OP_DIV};
         CH_ADD:    r = {1'b1, OP_ADD};
         CH_SUB:    r = {1'b1, OP_SUB};
         default:   r = {1'b0, OP_PAREN};
      endcase
      return r;
   endfunction

   // codes above the last operator fold back (mod 6)
   function automatic logic [CODE_W-1:0] norm_code(input logic [CODE_W-1:0] c);
      logic [CODE_W-1:0] r;
      case (c)
         3'd6:    r = OP_PAREN;
         3'd7:    r = OP_POW;
         default: r = c;
      endcase
      return r;
   endfunction

   function automatic logic [CHAR_W-1:0] char_of_code(input logic [CODE_W-1:0] c);
      logic [CHAR_W-1:0] r;
      case (c)
         OP_POW:  r = CH_POW;
         OP_MUL:  r = CH_MUL;
         OP_DIV:  r = CH_DIV;
         OP_ADD:  r = CH_ADD;
         OP_SUB:  r = CH_SUB;
         default: r = CH_LPAREN;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] rank_of(input logic [CODE_W-1:0] c);
      logic [1:0] r;
      case (c)
         OP_POW:         r = 2'd3;
         OP_MUL, OP_DIV: r = 2'd2;
         OP_ADD, OP_SUB: r = 2'd1;
         default:        r = 2'd0;
      endcase
      return r;
   endfunction

endpackage

### src/i2p_ram.sv
// Generic single-write, single-read RAM with registered read data.
module i2p_ram #(
   parameter int WIDTH = 3,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### src/infix_to_postfix_converter.sv
// Top level: microcoded shunting-yard infix to postfix converter.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | req_char_in, req_expr_end
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_char_out, rsp_symbol_valid,
//           |           |                      | rsp_error_code, rsp_last_of_expr
//
// One microcode step per cycle unless frozen by rsp_stall; one request at a time. A
// letter or bad character is emitted, '(' is pushed, an operator emits stacked
// entries until a stop and is then pushed, ')' emits down to its '(', and expr_end
// flushes the stack. A pop costs a step for the stack RAM's registered read. Results
// pass through a one-deep hold register (so the final one can be flagged) and the rsp
// output register. reset is synchronous and empties the stack; rsp_stall freezes the
// sequencer at any result-producing step while both result registers are full.
`include "assert_macros.svh"

module infix_to_postfix_converter (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [i2p_pkg::CHAR_W-1:0]  req_char_in,
   input  logic                        req_expr_end,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [i2p_pkg::CHAR_W-1:0]  rsp_char_out,
   output logic                        rsp_symbol_valid,
   output logic [i2p_pkg::ERR_W-1:0]   rsp_error_code,
   output logic                        rsp_last_of_expr
);

   localparam int CNT_W  = i2p_pkg::CNT_W;
   localparam int ADDR_W = i2p_pkg::ADDR_W;
   localparam int CHAR_W = i2p_pkg::CHAR_W;
   localparam int ERR_W  = i2p_pkg::ERR_W;
   localparam int CODE_W = i2p_pkg::CODE_W;
   localparam int STEP_W = i2p_pkg::STEP_W;

   logic [STEP_W-1:0] pc_ff, pc_in;
   i2p_pkg::cword_type cword;

   logic [CHAR_W-1:0] char_ff, char_in;
   logic              end_ff, end_in;
   logic              open_ff, open_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   logic              pend_valid_ff, pend_valid_in;
   logic [CHAR_W-1:0] pend_char_ff, pend_char_in;
   logic              pend_sym_ff, pend_sym_in;
   logic [ERR_W-1:0]  pend_err_ff, pend_err_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0] rsp_char_ff, rsp_char_in;
   logic              rsp_sym_ff, rsp_sym_in;
   logic [ERR_W-1:0]  rsp_err_ff, rsp_err_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              ram_we;
   logic [CODE_W-1:0] ram_rdata;
   logic [CNT_W-1:0]  cnt_m1;

   logic              req_fire, out_free, go;
   logic [CODE_W:0]   cur_lookup;
   logic              cur_is_op, cur_letter, cur_close, cnt_zero, full, stop, take;
   logic [CODE_W-1:0] cur_code, top_code;
   logic [1:0]        cur_rank, top_rank;
   logic [STEP_W-1:0] disp_target;

   logic              new_emit, release_pend, load_out;
   logic [CHAR_W-1:0] new_char;
   logic              new_sym;
   logic [ERR_W-1:0]  new_err;

   assign cword     = i2p_pkg::ucode_rom(pc_ff);
   assign req_stall = (pc_ff != i2p_pkg::STEP_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   // a step that may produce a result waits until the hold register can drain
   assign go        = !(cword.out_use && pend_valid_ff && !out_free);

   assign cnt_m1   = cnt_ff - CNT_W'(1);
   assign cnt_zero = (cnt_ff == '0);
   assign full     = (cnt_ff >= CNT_W'(i2p_pkg::STACK_DEPTH));

   i2p_ram #(.WIDTH(CODE_W), .DEPTH(i2p_pkg::STACK_DEPTH)) u_stack (
      .clock (clock),
      .we    (ram_we),
      .waddr (cnt_ff[ADDR_W-1:0]),
      .wdata (cur_code),
      .raddr (cnt_m1[ADDR_W-1:0]),
      .rdata (ram_rdata)
   );

   always_comb begin
      cur_lookup = i2p_pkg::op_lookup(char_ff);
      cur_is_op  = cur_lookup[CODE_W];
      cur_code   = cur_lookup[CODE_W-1:0];
      cur_rank   = i2p_pkg::rank_of(cur_code);
      cur_close  = (char_ff == i2p_pkg::CH_RPAREN);
      cur_letter = char_ff inside {[i2p_pkg::CH_UPPER_A:i2p_pkg::CH_UPPER_Z],
                                   [i2p_pkg::CH_LOWER_A:i2p_pkg::CH_LOWER_Z]};
      top_code   = i2p_pkg::norm_code(ram_rdata);
      top_rank   = i2p_pkg::rank_of(top_code);
      // stop popping at '(' or at a lower rank; ^ stops at its own rank too
      stop = (top_code == i2p_pkg::OP_PAREN) || (top_rank < cur_rank) ||
             ((top_rank == cur_rank) && (cur_code == i2p_pkg::OP_POW));

      if (cur_letter) begin
         disp_target = i2p_pkg::STEP_LET;
      end else if (cur_close) begin
         disp_target = i2p_pkg::STEP_CLS;
      end else if (cur_is_op && (cur_code == i2p_pkg::OP_PAREN)) begin
         disp_target = i2p_pkg::STEP_PUSH;
      end else if (cur_is_op) begin
         disp_target = i2p_pkg::STEP_OPC;
      end else begin
         disp_target = i2p_pkg::STEP_BAD;
      end
   end

   // sequencer
   always_comb begin
      take = 1'b0;
      case (cword.jmp)
         i2p_pkg::J_NEXT:        take = 1'b0;
         i2p_pkg::J_GOTO:        take = 1'b1;
         i2p_pkg::J_IF_NOT_FIRE: take = !req_fire;
         i2p_pkg::J_DISPATCH:    take = 1'b1;
         i2p_pkg::J_IF_CNT0:     take = cnt_zero;
         i2p_pkg::J_IF_PAREN:    take = (top_code == i2p_pkg::OP_PAREN);
         i2p_pkg::J_IF_STOP:     take = stop;
         i2p_pkg::J_IF_NOT_END:  take = !end_ff;
         default:                take = 1'b1;
      endcase

      if (!go) begin
         pc_in = pc_ff;
      end else if (cword.jmp == i2p_pkg::J_DISPATCH) begin
         pc_in = disp_target;
      end else if (take) begin
         pc_in = cword.target;
      end else begin
         pc_in = pc_ff + STEP_W'(1);
      end
   end

   // datapath actions
   always_comb begin
      char_in      = char_ff;
      end_in       = end_ff;
      open_in      = open_ff;
      cnt_in       = cnt_ff;
      ram_we       = 1'b0;
      new_emit     = 1'b0;
      new_char     = '0;
      new_sym      = 1'b0;
      new_err      = i2p_pkg::ERR_NONE;
      release_pend = 1'b0;

      if (go) begin
         case (cword.act)
            i2p_pkg::A_LATCH: begin
               if (req_fire) begin
                  char_in = req_char_in;
                  end_in  = req_expr_end;
                  open_in = 1'b0;
               end
            end
            i2p_pkg::A_LETTER: begin
               new_emit = 1'b1;
               new_char = char_ff;
               new_sym  = 1'b1;
            end
            i2p_pkg::A_BAD: begin
               new_emit = 1'b1;
               new_err  = i2p_pkg::ERR_BAD_CHAR;
               cnt_in   = '0;
            end
            i2p_pkg::A_EMIT_TOP: begin
               new_emit = 1'b1;
               new_char = i2p_pkg::char_of_code(top_code);
               new_sym  = 1'b1;
               cnt_in   = cnt_m1;
            end
            i2p_pkg::A_POP: begin
               cnt_in = cnt_m1;
            end
            i2p_pkg::A_ERR_CLOSE: begin
               new_emit = 1'b1;
               new_err  = i2p_pkg::ERR_CLOSE;
            end
            i2p_pkg::A_PUSH: begin
               if (full) begin
                  new_emit = 1'b1;
                  new_err  = i2p_pkg::ERR_OVERFLOW;
                  cnt_in   = '0;
               end else begin
                  ram_we = 1'b1;
                  cnt_in = cnt_ff + CNT_W'(1);
               end
            end
            i2p_pkg::A_POP_FLUSH: begin
               cnt_in = cnt_m1;
               if (top_code == i2p_pkg::OP_PAREN) begin
                  open_in = 1'b1;
               end else begin
                  new_emit = 1'b1;
                  new_char = i2p_pkg::char_of_code(top_code);
                  new_sym  = 1'b1;
               end
            end
            i2p_pkg::A_TAIL: begin
               // unmatched '(' marker, or a bare end marker if nothing came out
               if (open_ff) begin
                  new_emit = 1'b1;
                  new_err  = i2p_pkg::ERR_OPEN;
               end else if (!pend_valid_ff) begin
                  new_emit = 1'b1;
               end
            end
            i2p_pkg::A_RELEASE: begin
               release_pend = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // hold register and output register
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_char_in  = pend_char_ff;
      pend_sym_in   = pend_sym_ff;
      pend_err_in   = pend_err_ff;
      load_out      = 1'b0;
      rsp_last_in   = rsp_last_ff;

      if (new_emit) begin
         load_out      = pend_valid_ff;
         rsp_last_in   = pend_valid_ff ? 1'b0 : rsp_last_ff;
         pend_valid_in = 1'b1;
         pend_char_in  = new_char;
         pend_sym_in   = new_sym;
         pend_err_in   = new_err;
      end else if (release_pend && pend_valid_ff) begin
         load_out      = 1'b1;
         rsp_last_in   = end_ff;
         pend_valid_in = 1'b0;
      end

      rsp_valid_in = load_out || (rsp_valid_ff && rsp_stall);
      rsp_char_in  = load_out ? pend_char_ff : rsp_char_ff;
      rsp_sym_in   = load_out ? pend_sym_ff : rsp_sym_ff;
      rsp_err_in   = load_out ? pend_err_ff : rsp_err_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff         <= i2p_pkg::STEP_IDLE;
         cnt_ff        <= '0;
         open_ff       <= 1'b0;
         end_ff        <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pc_ff         <= pc_in;
         cnt_ff        <= cnt_in;
         open_ff       <= open_in;
         end_ff        <= end_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff      <= char_in;
      pend_char_ff <= pend_char_in;
      pend_sym_ff  <= pend_sym_in;
      pend_err_ff  <= pend_err_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_sym_ff   <= rsp_sym_in;
      rsp_err_ff   <= rsp_err_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_char_out     = rsp_char_ff;
   assign rsp_symbol_valid = rsp_sym_ff;
   assign rsp_error_code   = rsp_err_ff;
   assign rsp_last_of_expr = rsp_last_ff;

   `ASSERT_HOLDS(a_cnt_bound, clock, reset, cnt_ff <= CNT_W'(i2p_pkg::STACK_DEPTH), "stack count beyond depth")
   `ASSERT_HOLDS(a_idle_drained, clock, reset, (pc_ff != i2p_pkg::STEP_IDLE) || !pend_valid_ff, "result held while idle")
   `ASSERT_NEXT(a_accept_dispatch, clock, reset, req_valid && !req_stall, pc_ff == i2p_pkg::STEP_DISP, "request not dispatched")

endmodule
